>>> rtl/dft_pkg.sv
// ----------------------------------------------------------------------------
// dft_pkg
// Shared types and constants of the delimited field tokenizer.
// ----------------------------------------------------------------------------
package dft_pkg;

  localparam int DEF_OFFSET_BITS = 32;
  localparam int DEF_ROW_BITS    = 24;
  localparam int DEF_COLUMN_BITS = 16;

  localparam int KIND_W = 3;
  localparam int OFF_W  = 32;
  localparam int ROW_W  = 24;
  localparam int COL_W  = 16;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // register indexes
  localparam logic [2:0] REG_DELIMITER = 3'd0;
  localparam logic [2:0] REG_QUOTE     = 3'd1;
  localparam logic [2:0] REG_COMMENT   = 3'd2;
  localparam logic [2:0] REG_CMT_EN    = 3'd3;
  localparam logic [2:0] REG_BSL_ESC   = 3'd4;
  localparam logic [2:0] REG_DQ_ESC    = 3'd5;
  localparam logic [2:0] REG_SKIP_BLK  = 3'd6;
  localparam logic [2:0] REG_EMPTY_MIS = 3'd7;

  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_BSL   = 8'd92;
  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_SPACE = 8'd32;

  // queue between parser and output stage, power of two
  localparam int Q_DEPTH = 4;

  typedef enum logic [KIND_W-1:0] {
    KIND_PLAIN   = 3'd0,
    KIND_QUOTED  = 3'd1,
    KIND_EMPTY   = 3'd2,
    KIND_MISSING = 3'd3,
    KIND_END     = 3'd4
  } tok_kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_t;

  typedef struct packed {
    tok_kind_t          token_kind;
    logic [OFF_W-1:0]   start_offset;
    logic [OFF_W-1:0]   end_offset;
    logic [ROW_W-1:0]   row_number;
    logic [COL_W-1:0]   column_number;
    logic               needs_unescape;
    logic               contains_nul;
    logic               last_token;
  } tok_t;

  typedef struct packed {
    logic [7:0] delimiter_byte;
    logic [7:0] quote_byte;
    logic [7:0] comment_byte;
    logic       comment_enable;
    logic       backslash_escapes;
    logic       doubled_quote_escapes;
    logic       skip_blank_rows;
    logic       empty_is_missing;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    delimiter_byte:        8'd44,
    quote_byte:            8'd34,
    comment_byte:          8'd35,
    comment_enable:        1'b0,
    backslash_escapes:     1'b0,
    doubled_quote_escapes: 1'b1,
    skip_blank_rows:       1'b1,
    empty_is_missing:      1'b1
  };

  // queue write side: up to two descriptors per byte, slot 1 only with slot 0
  typedef struct packed {
    logic v0;
    logic v1;
    tok_t d0;
    tok_t d1;
  } q_wr_t;

endpackage

>>> rtl/dft_front.sv
// ----------------------------------------------------------------------------
// dft_front
// Parse machine: takes a byte a cycle unless stalled, emits token descriptors.
// ----------------------------------------------------------------------------
module dft_front #(
  parameter int OFFSET_BITS = dft_pkg::DEF_OFFSET_BITS,
  parameter int ROW_BITS    = dft_pkg::DEF_ROW_BITS,
  parameter int COLUMN_BITS = dft_pkg::DEF_COLUMN_BITS
) (
  input  logic           clk,
  input  logic           rst_n,
  input  dft_pkg::cfg_t  cfg,
  input  logic           in_valid,
  input  logic           in_stall,
  input  dft_pkg::in_t   in_data,
  output dft_pkg::q_wr_t q_wr
);
  import dft_pkg::*;

  typedef enum logic [2:0] {
    ST_DELIM, ST_FIELD, ST_STRING, ST_QUOTE,
    ST_STRING_END, ST_ESC_F, ST_ESC_S, ST_COMMENT
  } pstate_t;

  localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;
  localparam logic [ROW_BITS-1:0]    ROW_MAX = '1;
  localparam logic [COLUMN_BITS-1:0] COL_MAX = '1;
  localparam logic [OFFSET_BITS-1:0] OFF_ONE = OFFSET_BITS'(1);

  pstate_t                state_r, state_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [OFFSET_BITS-1:0] ts_r, ts_nxt;
  logic [ROW_BITS-1:0]    row_r, row_nxt;
  logic [COLUMN_BITS-1:0] col_r, col_nxt;
  logic                   sb_r, sb_nxt;
  logic                   sdq_r, sdq_nxt;
  logic                   snul_r, snul_nxt;
  logic                   swl_r, swl_nxt;
  logic                   done_r, done_nxt;

  logic                   take;
  logic [OFFSET_BITS-1:0] pos_inc;
  logic [ROW_BITS-1:0]    row_inc;
  logic [COLUMN_BITS-1:0] col_inc;
  logic                   eol, cmt, bsl, is_delim, is_quote;
  tok_kind_t              empty_kind;
  tok_t                   tok_a, tok_b;
  logic                   va, vb;

  function automatic tok_t mk_tok(tok_kind_t kind, logic [OFFSET_BITS-1:0] s,
                                  logic [OFFSET_BITS-1:0] e, logic esc,
                                  logic nul, logic [ROW_BITS-1:0] row,
                                  logic [COLUMN_BITS-1:0] col);
    tok_t t;
    t.token_kind     = kind;
    t.start_offset   = OFF_W'(s);
    t.end_offset     = OFF_W'(e);
    t.row_number     = ROW_W'(row);
    t.column_number  = COL_W'(col);
    t.needs_unescape = esc;
    t.contains_nul   = nul;
    t.last_token     = 1'b0;
    return t;
  endfunction

  assign take       = in_valid && !in_stall && !done_r;
  assign pos_inc    = (pos_r == OFF_MAX) ? pos_r : pos_r + OFF_ONE;
  assign row_inc    = (row_r == ROW_MAX) ? row_r : row_r + ROW_BITS'(1);
  assign col_inc    = (col_r == COL_MAX) ? col_r : col_r + COLUMN_BITS'(1);
  assign eol        = (in_data.data_byte == CH_CR) || (in_data.data_byte == CH_LF);
  assign cmt        = cfg.comment_enable && (in_data.data_byte == cfg.comment_byte);
  assign bsl        = cfg.backslash_escapes && (in_data.data_byte == CH_BSL);
  assign is_delim   = in_data.data_byte == cfg.delimiter_byte;
  assign is_quote   = in_data.data_byte == cfg.quote_byte;
  assign empty_kind = cfg.empty_is_missing ? KIND_MISSING : KIND_EMPTY;

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    ts_nxt    = ts_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    sb_nxt    = sb_r;
    sdq_nxt   = sdq_r;
    snul_nxt  = snul_r;
    swl_nxt   = swl_r;
    done_nxt  = done_r;
    tok_a     = '0;
    tok_b     = '0;
    va        = 1'b0;
    vb        = 1'b0;
    if (take) begin
      pos_nxt = pos_inc;
      if (swl_r) begin
        swl_nxt = 1'b0;
      end
      if (swl_r && in_data.data_byte == CH_LF) begin
        ts_nxt = pos_inc;
      end else begin
        if (in_data.data_byte == CH_NUL) begin
          snul_nxt = 1'b1;
        end
        unique case (state_r) inside
          ST_DELIM: begin
            if (in_data.data_byte == CH_SPACE) begin
              state_nxt = ST_DELIM;
            end else if (eol) begin
              if (!(col_r == '0 && cfg.skip_blank_rows)) begin
                tok_a    = mk_tok(empty_kind, '0, '0, 1'b0, 1'b0, row_r, col_r);
                va       = 1'b1;
                sb_nxt   = 1'b0;
                sdq_nxt  = 1'b0;
                snul_nxt = 1'b0;
                row_nxt  = row_inc;
                col_nxt  = '0;
              end
              ts_nxt  = pos_inc;
              swl_nxt = in_data.data_byte == CH_CR;
            end else if (cmt) begin
              state_nxt = ST_COMMENT;
            end else if (is_delim) begin
              tok_a    = mk_tok(empty_kind, '0, '0, 1'b0, 1'b0, row_r, col_r);
              va       = 1'b1;
              sb_nxt   = 1'b0;
              sdq_nxt  = 1'b0;
              snul_nxt = 1'b0;
              col_nxt  = col_inc;
              ts_nxt   = pos_inc;
            end else if (is_quote) begin
              ts_nxt    = pos_r;
              state_nxt = ST_STRING;
            end else if (bsl) begin
              state_nxt = ST_ESC_F;
            end else begin
              state_nxt = ST_FIELD;
            end
          end
          ST_FIELD: begin
            if (eol || cmt || (!bsl && is_delim)) begin
              tok_a    = mk_tok(KIND_PLAIN, ts_r, pos_r, sb_r, snul_nxt, row_r, col_r);
              va       = 1'b1;
              sb_nxt   = 1'b0;
              sdq_nxt  = 1'b0;
              snul_nxt = 1'b0;
              ts_nxt   = pos_inc;
              if (eol) begin
                row_nxt   = row_inc;
                col_nxt   = '0;
                state_nxt = ST_DELIM;
                swl_nxt   = in_data.data_byte == CH_CR;
              end else begin
                col_nxt   = col_inc;
                state_nxt = cmt ? ST_COMMENT : ST_DELIM;
              end
            end else if (bsl) begin
              state_nxt = ST_ESC_F;
            end
          end
          ST_ESC_F: begin
            sb_nxt    = 1'b1;
            state_nxt = ST_FIELD;
          end
          ST_QUOTE, ST_STRING_END: begin
            if (state_r == ST_QUOTE && is_quote) begin
              sdq_nxt   = 1'b1;
              state_nxt = ST_STRING;
            end else if (eol || cmt || is_delim) begin
              tok_a    = mk_tok(KIND_QUOTED, ts_r + OFF_ONE, pos_r - OFF_ONE,
                                sb_r || sdq_r, snul_nxt, row_r, col_r);
              va       = 1'b1;
              sb_nxt   = 1'b0;
              sdq_nxt  = 1'b0;
              snul_nxt = 1'b0;
              ts_nxt   = pos_inc;
              if (eol) begin
                row_nxt   = row_inc;
                col_nxt   = '0;
                state_nxt = ST_DELIM;
                swl_nxt   = in_data.data_byte == CH_CR;
              end else begin
                col_nxt   = col_inc;
                state_nxt = cmt ? ST_COMMENT : ST_DELIM;
              end
            end else begin
              state_nxt = (state_r == ST_QUOTE) ? ST_STRING : ST_FIELD;
            end
          end
          ST_STRING: begin
            if (is_quote) begin
              state_nxt = cfg.doubled_quote_escapes ? ST_QUOTE : ST_STRING_END;
            end else if (bsl) begin
              state_nxt = ST_ESC_S;
            end
          end
          ST_ESC_S: begin
            sb_nxt    = 1'b1;
            state_nxt = ST_STRING;
          end
          ST_COMMENT: begin
            if (eol) begin
              if (col_r != '0) begin
                row_nxt = row_inc;
                col_nxt = '0;
              end
              ts_nxt    = pos_inc;
              swl_nxt   = in_data.data_byte == CH_CR;
              state_nxt = ST_DELIM;
            end
          end
        endcase
      end
      if (in_data.final_byte) begin
        done_nxt = 1'b1;
        vb       = 1'b1;
        unique case (state_nxt) inside
          ST_DELIM: begin
            if (col_nxt != '0) begin
              tok_b = mk_tok(empty_kind, '0, '0, 1'b0, 1'b0, row_nxt, col_nxt);
            end else begin
              tok_b = mk_tok(KIND_END, '0, '0, 1'b0, 1'b0, row_nxt, col_nxt);
            end
          end
          ST_QUOTE, ST_STRING_END: begin
            tok_b = mk_tok(KIND_QUOTED, ts_nxt + OFF_ONE, pos_r,
                           sb_nxt || sdq_nxt, snul_nxt, row_nxt, col_nxt);
          end
          ST_STRING: begin
            tok_b = mk_tok(KIND_QUOTED, ts_nxt + OFF_ONE, pos_inc,
                           sb_nxt || sdq_nxt, snul_nxt, row_nxt, col_nxt);
          end
          ST_ESC_F, ST_ESC_S: begin
            tok_b = mk_tok(KIND_QUOTED, ts_nxt, pos_r,
                           sb_nxt || sdq_nxt, snul_nxt, row_nxt, col_nxt);
          end
          ST_FIELD: begin
            tok_b = mk_tok(KIND_PLAIN, ts_nxt, pos_inc, sb_nxt, snul_nxt,
                           row_nxt, col_nxt);
          end
          ST_COMMENT: begin
            tok_b = mk_tok(KIND_END, '0, '0, 1'b0, 1'b0, row_nxt, col_nxt);
          end
        endcase
        tok_b.last_token = 1'b1;
        sb_nxt   = 1'b0;
        sdq_nxt  = 1'b0;
        snul_nxt = 1'b0;
      end
    end
  end

  // pack into queue slots in stream order
  always_comb begin
    q_wr.v0 = va || vb;
    q_wr.v1 = va && vb;
    q_wr.d0 = va ? tok_a : tok_b;
    q_wr.d1 = tok_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_DELIM;
      pos_r   <= '0;
      ts_r    <= '0;
      row_r   <= '0;
      col_r   <= '0;
      sb_r    <= 1'b0;
      sdq_r   <= 1'b0;
      snul_r  <= 1'b0;
      swl_r   <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      ts_r    <= ts_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      sb_r    <= sb_nxt;
      sdq_r   <= sdq_nxt;
      snul_r  <= snul_nxt;
      swl_r   <= swl_nxt;
      done_r  <= done_nxt;
    end
  end

endmodule

>>> rtl/dft_queue.sv
// ----------------------------------------------------------------------------
// dft_queue
// Short descriptor queue: up to two writes and one read per cycle.
// ----------------------------------------------------------------------------
module dft_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  dft_pkg::q_wr_t q_wr,
  output logic           q_space,
  output logic           q_valid,
  output dft_pkg::tok_t  q_data,
  input  logic           q_take
);
  import dft_pkg::*;

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  tok_t             mem [Q_DEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [PTR_W-1:0] rp_r, rp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] n_wr;

  assign n_wr    = CNT_W'(q_wr.v0) + CNT_W'(q_wr.v1);
  assign q_space = cnt_r <= CNT_W'(Q_DEPTH - 2);
  assign q_valid = cnt_r != '0;
  assign q_data  = mem[rp_r];

  always_comb begin
    wp_nxt  = wp_r + PTR_W'(n_wr);
    rp_nxt  = q_take ? rp_r + PTR_W'(1) : rp_r;
    cnt_nxt = cnt_r + n_wr - CNT_W'(q_take);
  end

  always_ff @(posedge clk) begin
    if (q_wr.v0) begin
      mem[wp_r] <= q_wr.d0;
    end
    if (q_wr.v1) begin
      mem[wp_r + PTR_W'(1)] <= q_wr.d1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> rtl/dft_back.sv
// ----------------------------------------------------------------------------
// dft_back
// Output stage: moves descriptors from the queue into the result register.
// ----------------------------------------------------------------------------
module dft_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  dft_pkg::tok_t q_data,
  output logic          q_take,
  output logic          out_valid,
  input  logic          out_stall,
  output dft_pkg::tok_t out_data
);
  import dft_pkg::*;

  logic out_valid_r, out_valid_nxt;
  tok_t out_data_r;

  assign q_take        = q_valid && (!out_valid_r || !out_stall);
  assign out_valid_nxt = q_take || (out_valid_r && out_stall);
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

  always_ff @(posedge clk) begin
    if (q_take) begin
      out_data_r <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/delimited_field_tokenizer_core.sv
// ----------------------------------------------------------------------------
// delimited_field_tokenizer_core
// Splits delimited text into fields; one descriptor per field or stream end.
// ----------------------------------------------------------------------------
// The block takes one byte every cycle while not stalled. The parser writes
// the descriptors of a byte into a four-entry queue, and the output register
// drains it at one descriptor per cycle while the receiver does not stall. A
// byte that closes a field and also ends the stream gives two descriptors,
// both written to the queue together; the input stalls while fewer than two
// queue entries are free. There is no clearing pass after reset.
// Configuration is written through the register port while the block is
// idle: the user is bound to this, as the block itself does not enforce it.
module delimited_field_tokenizer_core #(
  parameter int OFFSET_BITS = dft_pkg::DEF_OFFSET_BITS,
  parameter int ROW_BITS    = dft_pkg::DEF_ROW_BITS,
  parameter int COLUMN_BITS = dft_pkg::DEF_COLUMN_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  dft_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output dft_pkg::tok_t                  out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dft_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [dft_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [dft_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import dft_pkg::*;

  cfg_t       cfg_r;
  logic       cfg_wr;
  logic [2:0] reg_idx;
  q_wr_t      q_wr;
  logic       q_space, q_valid, q_take;
  tok_t       q_data;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign reg_idx  = paddr[4:2];
  assign in_stall = !q_space;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_DELIMITER: cfg_r.delimiter_byte        <= pwdata[7:0];
        REG_QUOTE:     cfg_r.quote_byte            <= pwdata[7:0];
        REG_COMMENT:   cfg_r.comment_byte          <= pwdata[7:0];
        REG_CMT_EN:    cfg_r.comment_enable        <= pwdata[0];
        REG_BSL_ESC:   cfg_r.backslash_escapes     <= pwdata[0];
        REG_DQ_ESC:    cfg_r.doubled_quote_escapes <= pwdata[0];
        REG_SKIP_BLK:  cfg_r.skip_blank_rows       <= pwdata[0];
        REG_EMPTY_MIS: cfg_r.empty_is_missing      <= pwdata[0];
        default:       cfg_r <= cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DELIMITER: prdata = CFG_DATA_W'(cfg_r.delimiter_byte);
      REG_QUOTE:     prdata = CFG_DATA_W'(cfg_r.quote_byte);
      REG_COMMENT:   prdata = CFG_DATA_W'(cfg_r.comment_byte);
      REG_CMT_EN:    prdata = CFG_DATA_W'(cfg_r.comment_enable);
      REG_BSL_ESC:   prdata = CFG_DATA_W'(cfg_r.backslash_escapes);
      REG_DQ_ESC:    prdata = CFG_DATA_W'(cfg_r.doubled_quote_escapes);
      REG_SKIP_BLK:  prdata = CFG_DATA_W'(cfg_r.skip_blank_rows);
      REG_EMPTY_MIS: prdata = CFG_DATA_W'(cfg_r.empty_is_missing);
      default:       prdata = '0;
    endcase
  end

  dft_front #(
    .OFFSET_BITS (OFFSET_BITS),
    .ROW_BITS    (ROW_BITS),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_wr     (q_wr)
  );

  dft_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_wr    (q_wr),
    .q_space (q_space),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_take  (q_take)
  );

  dft_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_take    (q_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> rtl/dft_checker.sv
// ----------------------------------------------------------------------------
// dft_checker
// Port-level checks of the tokenizer result channel.
// ----------------------------------------------------------------------------
module dft_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          out_valid,
  input logic          out_stall,
  input dft_pkg::tok_t out_data
);
  import dft_pkg::*;

  // stalled transfer holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.token_kind == KIND_END |-> out_data.last_token)
    else $error("end of source token not marked last");

  // spanless tokens carry no span or flags
  a_spanless: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.token_kind == KIND_EMPTY ||
                  out_data.token_kind == KIND_MISSING ||
                  out_data.token_kind == KIND_END)
    |-> out_data.start_offset == '0 && out_data.end_offset == '0 &&
        !out_data.needs_unescape && !out_data.contains_nul)
    else $error("spanless token with span or flags");

endmodule

bind delimited_field_tokenizer_core dft_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

>>> test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the delimited field tokenizer core. A short table of bytes
// covers reset behavior, line ends, blank rows, spaces, zero bytes and quoted
// fields, then phases of random configuration send record-shaped text with
// noise mixed in. A local parser predicts each token no table row gives, and
// each result transfer is checked against the oldest prediction while both
// sides idle and stall at random. The stream is closed once, on a backslash escape.
// ----------------------------------------------------------------------------
module tb;
  import dft_pkg::*;

  typedef enum logic [2:0] {
    P_DELIM, P_FIELD, P_STRING, P_QUOTE, P_STR_END, P_ESC_F, P_ESC_S, P_COMMENT
  } parse_t;

  typedef struct {
    logic [7:0] data;
    bit         typed;
    int         count;
    tok_t       tok;
  } stim_row_t;

  localparam logic [7:0] COMMA  = 8'h2C;
  localparam logic [7:0] DQUOTE = 8'h22;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_t                   in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  tok_t                  out_data;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  delimited_field_tokenizer_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // parser mirror
  cfg_t        mirror_cfg = CFG_RESET;
  parse_t      ps = P_DELIM;
  logic [31:0] cur_pos = '0;
  logic [31:0] tok_begin = '0;
  logic [23:0] rec_no = '0;
  logic [15:0] fld_no = '0;
  bit          saw_bsl, saw_dq, saw_nul, eat_lf, closed;
  tok_t        step_tok [2];
  int          step_n;

  tok_t        pending_tokens [$];
  stim_row_t   dir_rows [$];
  int          bad_transfers = 0;
  int          bytes_sent = 0;
  bit          quiet = 1'b0;
  int          stall_run = 0;

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic tok_t missing_at(logic [23:0] r, logic [15:0] c);
    tok_t t;
    t = '0;
    t.token_kind = KIND_MISSING;
    t.row_number = r;
    t.column_number = c;
    return t;
  endfunction

  function automatic string tok_str(tok_t t);
    return $sformatf("kind=%0d start=%h end=%h row=%0d col=%0d esc=%b nul=%b last=%b",
                     t.token_kind, t.start_offset, t.end_offset, t.row_number,
                     t.column_number, t.needs_unescape, t.contains_nul, t.last_token);
  endfunction

  function automatic logic [7:0] content_byte();
    if ($urandom_range(0, 99) < 85) return 8'($urandom_range(8'h61, 8'h7A));
    return 8'($urandom_range(0, 255));
  endfunction

  // append a predicted descriptor
  task automatic queue_tok(tok_t t);
    pending_tokens.insert(pending_tokens.size(), t);
  endtask

  // append a directed stimulus row
  task automatic add_row(logic [7:0] data, bit typed, int count, tok_t tok);
    stim_row_t row;
    row.data = data;
    row.typed = typed;
    row.count = count;
    row.tok = tok;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  task automatic emit(tok_kind_t kind, logic [31:0] s, logic [31:0] e, bit esc, bit nul);
    tok_t t;
    t.token_kind = kind;
    t.start_offset = s;
    t.end_offset = e;
    t.row_number = rec_no;
    t.column_number = fld_no;
    t.needs_unescape = esc;
    t.contains_nul = nul;
    t.last_token = 1'b0;
    step_tok[step_n] = t;
    step_n++;
    saw_bsl = 1'b0;
    saw_dq = 1'b0;
    saw_nul = 1'b0;
  endtask

  task automatic emit_span(tok_kind_t kind, logic [31:0] s, logic [31:0] e);
    emit(kind, s, e, saw_bsl || (kind == KIND_QUOTED && saw_dq), saw_nul);
  endtask

  task automatic emit_empty();
    emit(mirror_cfg.empty_is_missing ? KIND_MISSING : KIND_EMPTY, '0, '0, 1'b0, 1'b0);
  endtask

  task automatic next_field();
    if (fld_no != '1) fld_no = fld_no + 1'b1;
    ps = P_DELIM;
  endtask

  task automatic next_record();
    if (rec_no != '1) rec_no = rec_no + 1'b1;
    fld_no = '0;
    ps = P_DELIM;
  endtask

  // field closed by a line end, a comment or a delimiter
  task automatic after_close(bit eol, bit cmt, logic [7:0] b, logic [31:0] nxt);
    tok_begin = nxt;
    if (eol) begin
      next_record();
      eat_lf = (b == CH_CR);
    end else begin
      next_field();
      if (cmt) ps = P_COMMENT;
    end
  endtask

  task automatic tokenize_byte(logic [7:0] b, bit fin);
    logic [31:0] pos, nxt;
    bit eol, cmt, bsl, skip;
    step_n = 0;
    if (closed) return;
    pos = cur_pos;
    nxt = (pos == '1) ? pos : pos + 1'b1;
    cur_pos = nxt;
    skip = eat_lf && (b == CH_LF);
    eat_lf = 1'b0;
    if (skip) begin
      tok_begin = nxt;
    end else begin
      if (b == CH_NUL) saw_nul = 1'b1;
      eol = (b == CH_CR) || (b == CH_LF);
      cmt = mirror_cfg.comment_enable && (b == mirror_cfg.comment_byte);
      bsl = mirror_cfg.backslash_escapes && (b == CH_BSL);
      case (ps)
        P_DELIM: begin
          if (b == CH_SPACE) begin
          end else if (eol) begin
            if (fld_no == '0 && mirror_cfg.skip_blank_rows) begin
              tok_begin = nxt;
            end else begin
              emit_empty();
              next_record();
              tok_begin = nxt;
            end
            eat_lf = (b == CH_CR);
          end else if (cmt) begin
            ps = P_COMMENT;
          end else if (b == mirror_cfg.delimiter_byte) begin
            emit_empty();
            next_field();
            tok_begin = nxt;
          end else if (b == mirror_cfg.quote_byte) begin
            tok_begin = pos;
            ps = P_STRING;
          end else if (bsl) begin
            ps = P_ESC_F;
          end else begin
            ps = P_FIELD;
          end
        end
        P_FIELD: begin
          if (eol || cmt || (!bsl && b == mirror_cfg.delimiter_byte)) begin
            emit_span(KIND_PLAIN, tok_begin, pos);
            after_close(eol, cmt, b, nxt);
          end else if (bsl) begin
            ps = P_ESC_F;
          end
        end
        P_ESC_F: begin
          saw_bsl = 1'b1;
          ps = P_FIELD;
        end
        P_QUOTE, P_STR_END: begin
          if (ps == P_QUOTE && b == mirror_cfg.quote_byte) begin
            saw_dq = 1'b1;
            ps = P_STRING;
          end else if (eol || cmt || b == mirror_cfg.delimiter_byte) begin
            emit_span(KIND_QUOTED, tok_begin + 1'b1, pos - 1'b1);
            after_close(eol, cmt, b, nxt);
          end else begin
            ps = (ps == P_QUOTE) ? P_STRING : P_FIELD;
          end
        end
        P_STRING: begin
          if (b == mirror_cfg.quote_byte)
            ps = mirror_cfg.doubled_quote_escapes ? P_QUOTE : P_STR_END;
          else if (bsl)
            ps = P_ESC_S;
        end
        P_ESC_S: begin
          saw_bsl = 1'b1;
          ps = P_STRING;
        end
        default: begin
          if (eol) begin
            if (fld_no != '0) begin
              if (rec_no != '1) rec_no = rec_no + 1'b1;
              fld_no = '0;
            end
            tok_begin = nxt;
            eat_lf = (b == CH_CR);
            ps = P_DELIM;
          end
        end
      endcase
    end
    if (fin) begin
      closed = 1'b1;
      case (ps)
        P_DELIM: begin
          if (fld_no != '0) emit_empty();
          else emit(KIND_END, '0, '0, 1'b0, 1'b0);
        end
        P_QUOTE, P_STR_END: emit_span(KIND_QUOTED, tok_begin + 1'b1, pos);
        P_STRING: emit_span(KIND_QUOTED, tok_begin + 1'b1, nxt);
        P_ESC_F, P_ESC_S: emit_span(KIND_QUOTED, tok_begin, pos);
        P_FIELD: emit_span(KIND_PLAIN, tok_begin, nxt);
        default: emit(KIND_END, '0, '0, 1'b0, 1'b0);
      endcase
      step_tok[step_n-1].last_token = 1'b1;
    end
  endtask

  task automatic send_byte(logic [7:0] b, bit fin, bit use_model = 1'b1);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{b, fin};
    do @(posedge clk); while (in_stall !== 1'b0);
    bytes_sent++;
    tokenize_byte(b, fin);
    if (use_model)
      for (int k = 0; k < step_n; k++) queue_tok(step_tok[k]);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [7:0] val);
    logic [31:0] junk;
    junk = $urandom;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    if (idx <= REG_COMMENT) pwdata <= {junk[31:8], val};
    else pwdata <= {junk[31:1], val[0]};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (idx)
      REG_DELIMITER: mirror_cfg.delimiter_byte = val;
      REG_QUOTE:     mirror_cfg.quote_byte = val;
      REG_COMMENT:   mirror_cfg.comment_byte = val;
      REG_CMT_EN:    mirror_cfg.comment_enable = val[0];
      REG_BSL_ESC:   mirror_cfg.backslash_escapes = val[0];
      REG_DQ_ESC:    mirror_cfg.doubled_quote_escapes = val[0];
      REG_SKIP_BLK:  mirror_cfg.skip_blank_rows = val[0];
      default:       mirror_cfg.empty_is_missing = val[0];
    endcase
  endtask

  task automatic apply_config(cfg_t c);
    in_valid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    write_reg(REG_DELIMITER, c.delimiter_byte);
    write_reg(REG_QUOTE, c.quote_byte);
    write_reg(REG_COMMENT, c.comment_byte);
    write_reg(REG_CMT_EN, {7'd0, c.comment_enable});
    write_reg(REG_BSL_ESC, {7'd0, c.backslash_escapes});
    write_reg(REG_DQ_ESC, {7'd0, c.doubled_quote_escapes});
    write_reg(REG_SKIP_BLK, {7'd0, c.skip_blank_rows});
    write_reg(REG_EMPTY_MIS, {7'd0, c.empty_is_missing});
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  function automatic cfg_t random_cfg(int phase);
    cfg_t c;
    c.comment_enable = 1'($urandom_range(0, 1));
    c.backslash_escapes = 1'($urandom_range(0, 1));
    c.doubled_quote_escapes = 1'($urandom_range(0, 1));
    c.skip_blank_rows = 1'($urandom_range(0, 1));
    c.empty_is_missing = 1'($urandom_range(0, 1));
    case (phase)
      1: begin
        c = '1;
        c.delimiter_byte = 8'h00;
        c.comment_byte = 8'h01;
      end
      2: begin
        c = '0;
        c.delimiter_byte = 8'hFF;
        c.comment_byte = 8'hFE;
      end
      default: begin
        if ($urandom_range(0, 2) == 0) begin
          c.delimiter_byte = 8'($urandom_range(0, 255));
          c.quote_byte = 8'($urandom_range(0, 255));
          c.comment_byte = 8'($urandom_range(0, 255));
        end else begin
          case ($urandom_range(0, 3))
            0: c.delimiter_byte = COMMA;
            1: c.delimiter_byte = 8'h09;
            2: c.delimiter_byte = 8'h3B;
            default: c.delimiter_byte = 8'h7C;
          endcase
          c.quote_byte = $urandom_range(0, 1) ? DQUOTE : 8'h27;
          c.comment_byte = 8'h23;
        end
      end
    endcase
    return c;
  endfunction

  // one field and usually its separator, mostly well formed
  task automatic send_field();
    int r;
    logic [7:0] q;
    q = mirror_cfg.quote_byte;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      send_byte(q, 1'b0);
      repeat ($urandom_range(0, 6)) begin
        r = $urandom_range(0, 99);
        if (r < 12) begin
          send_byte(q, 1'b0);
          send_byte(q, 1'b0);
        end else if (r < 20) begin
          send_byte(CH_BSL, 1'b0);
          send_byte(content_byte(), 1'b0);
        end else begin
          send_byte(content_byte(), 1'b0);
        end
      end
      send_byte(q, 1'b0);
      if ($urandom_range(0, 19) == 0) send_byte(content_byte(), 1'b0);
    end else if (r < 85) begin
      repeat ($urandom_range(0, 1)) send_byte(CH_SPACE, 1'b0);
      repeat ($urandom_range(0, 6)) begin
        r = $urandom_range(0, 99);
        if (r < 5) begin
          send_byte(CH_BSL, 1'b0);
          send_byte(content_byte(), 1'b0);
        end else if (r < 8) begin
          send_byte(CH_NUL, 1'b0);
        end else if (r < 11) begin
          send_byte(8'hFF, 1'b0);
        end else begin
          send_byte(content_byte(), 1'b0);
        end
      end
    end else begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
    end
    r = $urandom_range(0, 99);
    if (r < 65) begin
      send_byte(mirror_cfg.delimiter_byte, 1'b0);
    end else if (r < 75) begin
      send_byte(CH_CR, 1'b0);
    end else if (r < 83) begin
      send_byte(CH_LF, 1'b0);
    end else if (r < 91) begin
      send_byte(CH_CR, 1'b0);
      send_byte(CH_LF, 1'b0);
    end else if (r < 96) begin
      send_byte(mirror_cfg.comment_byte, 1'b0);
      repeat ($urandom_range(0, 4)) send_byte(content_byte(), 1'b0);
      send_byte(CH_LF, 1'b0);
    end
  endtask

  // receiver stall bursts
  always @(posedge clk) begin
    if (stall_run > 0) begin
      out_stall <= 1'b1;
      stall_run <= stall_run - 1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 3) == 0) stall_run <= pick_gap();
    end
  end

  always @(posedge clk) begin : check_tokens
    tok_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending_tokens.size() == 0) begin
        if (bad_transfers < 10) $display("unexpected token: %s", tok_str(out_data));
        bad_transfers++;
      end else begin
        want = pending_tokens.pop_front();
        if (out_data !== want) begin
          if (bad_transfers < 10) begin
            $display("token mismatch at %0t", $realtime);
            $display("  expected %s", tok_str(want));
            $display("  actual   %s", tok_str(out_data));
          end
          bad_transfers++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("tb: errors");
    $finish;
  end

  initial begin
    int phase_end;
    int wait_cnt;
    cfg_t c;
    add_row(COMMA, 1'b1, 1, missing_at(0, 0));
    add_row(COMMA, 1'b1, 1, missing_at(0, 1));
    add_row(CH_LF, 1'b1, 1, missing_at(0, 2));
    add_row(CH_CR, 1'b1, 0, tok_t'(0));
    add_row(CH_LF, 1'b1, 0, tok_t'(0));
    add_row(CH_SPACE, 1'b1, 0, tok_t'(0));
    add_row(CH_SPACE, 1'b1, 0, tok_t'(0));
    add_row(COMMA, 1'b1, 1, missing_at(1, 0));
    add_row(8'h61, 1'b0, 0, tok_t'(0));
    add_row(8'hFF, 1'b0, 0, tok_t'(0));
    add_row(CH_NUL, 1'b0, 0, tok_t'(0));
    add_row(COMMA, 1'b0, 0, tok_t'(0));
    add_row(DQUOTE, 1'b0, 0, tok_t'(0));
    add_row(DQUOTE, 1'b0, 0, tok_t'(0));
    add_row(DQUOTE, 1'b0, 0, tok_t'(0));
    add_row(8'h78, 1'b0, 0, tok_t'(0));
    add_row(DQUOTE, 1'b0, 0, tok_t'(0));
    add_row(CH_CR, 1'b0, 0, tok_t'(0));
    add_row(CH_SPACE, 1'b0, 0, tok_t'(0));
    add_row(8'h62, 1'b0, 0, tok_t'(0));
    add_row(DQUOTE, 1'b0, 0, tok_t'(0));
    add_row(CH_LF, 1'b0, 0, tok_t'(0));
    add_row(CH_LF, 1'b0, 0, tok_t'(0));
    add_row(DQUOTE, 1'b0, 0, tok_t'(0));
    add_row(DQUOTE, 1'b0, 0, tok_t'(0));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].data, 1'b0, !dir_rows[i].typed);
      if (dir_rows[i].typed && dir_rows[i].count > 0)
        queue_tok(dir_rows[i].tok);
    end

    for (int p = 0; p < 8; p++) begin
      apply_config(random_cfg(p));
      quiet = ($urandom_range(0, 3) == 0);
      phase_end = bytes_sent + 78;
      while (bytes_sent < phase_end) send_field();
    end

    // close the stream on a backslash escape, then bytes that must be ignored
    c = mirror_cfg;
    c.backslash_escapes = 1'b1;
    apply_config(c);
    quiet = 1'b0;
    send_byte(CH_LF, 1'b0);
    send_byte(8'h71, 1'b0);
    send_byte(CH_BSL, 1'b1);
    repeat (3) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    in_valid <= 1'b0;

    wait_cnt = 0;
    while (pending_tokens.size() != 0 && wait_cnt < 50000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (10) @(posedge clk);
    bad_transfers += pending_tokens.size();
    if (bad_transfers == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule

>>> filelist.f
rtl/dft_pkg.sv
rtl/dft_front.sv
rtl/dft_queue.sv
rtl/dft_back.sv
rtl/delimited_field_tokenizer_core.sv
rtl/dft_checker.sv
test/tb.sv
